// File: design/rbf_pkg.sv
// Shared types and constants for the ray versus box face hit test.
// No dependencies; every other design file refers to this package by scope.
package rbf_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int DIR_FRAC_BITS_DEF = 16;
  localparam int FACE_WIDTH        = 3;
  localparam int CFG_IDX_WIDTH     = 3;

  // Face codes in the order they are tried.
  typedef enum logic [FACE_WIDTH-1:0] {
    FACE_NONE   = 3'd0,
    FACE_Z_LOW  = 3'd1,
    FACE_Z_HIGH = 3'd2,
    FACE_Y_LOW  = 3'd3,
    FACE_Y_HIGH = 3'd4,
    FACE_X_LOW  = 3'd5,
    FACE_X_HIGH = 3'd6
  } face_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_HALF_X   = 3'd3,
    REG_HALF_Y   = 3'd4,
    REG_HALF_Z   = 3'd5
  } cfg_idx_e;

  // Control tag that travels with each beat along the chain of cells.
  typedef struct packed {
    logic  valid;
    face_e face;
  } tag_t;

endpackage

// File: design/rbf_ifs.sv
// Handshake channel interfaces for the ray box face hit test unit.
// Depends on rbf_pkg for the face and register index widths.
interface rbf_ray_if #(
  parameter int COORD_WIDTH   = rbf_pkg::COORD_WIDTH_DEF,
  parameter int DIR_FRAC_BITS = rbf_pkg::DIR_FRAC_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [COORD_WIDTH-1:0]   origin_x;
  logic signed [COORD_WIDTH-1:0]   origin_y;
  logic signed [COORD_WIDTH-1:0]   origin_z;
  logic signed [DIR_FRAC_BITS+1:0] dir_x;
  logic signed [DIR_FRAC_BITS+1:0] dir_y;
  logic signed [DIR_FRAC_BITS+1:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rbf_hit_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [rbf_pkg::FACE_WIDTH-1:0] face;
  modport source (output valid, hit, face, input ready);
  modport sink   (input valid, hit, face, output ready);
endinterface

interface rbf_cfg_if #(
  parameter int COORD_WIDTH = rbf_pkg::COORD_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic [rbf_pkg::CFG_IDX_WIDTH-1:0] index;
  logic [COORD_WIDTH-1:0]            data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/rbf_face_cell.sv
// One cell of the chain: tests a single box face in three register stages.
// Depends on rbf_pkg for the tag struct and face codes.
module rbf_face_cell #(
  parameter int           COORD_WIDTH   = rbf_pkg::COORD_WIDTH_DEF,
  parameter int           DIR_FRAC_BITS = rbf_pkg::DIR_FRAC_BITS_DEF,
  parameter rbf_pkg::face_e FACE_ID     = rbf_pkg::FACE_Z_LOW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  rbf_pkg::tag_t                     tag_i,
  input  logic [2:0][COORD_WIDTH-1:0]       org_i,
  input  logic [2:0][DIR_FRAC_BITS+1:0]     dir_i,
  input  logic [2:0][COORD_WIDTH-1:0]       center_i,
  input  logic [2:0][COORD_WIDTH-2:0]       half_i,
  output rbf_pkg::tag_t                     tag_o,
  output logic [2:0][COORD_WIDTH-1:0]       org_o,
  output logic [2:0][DIR_FRAC_BITS+1:0]     dir_o
);
  localparam int DW   = DIR_FRAC_BITS + 2;
  localparam int NW   = COORD_WIDTH + 2;
  localparam int OW   = COORD_WIDTH + 1;
  localparam int PW   = COORD_WIDTH + DW + 3;
  localparam int FIDX = int'(FACE_ID);
  localparam int N    = 2 - (FIDX - 1) / 2;
  localparam int A    = (N == 0) ? 1 : 0;
  localparam int B    = (N == 2) ? 1 : 2;
  localparam bit HIGH = (FIDX % 2) == 0;

  // Stage 0: distance to the plane and offsets from the center.
  logic signed [NW-1:0] plane, num_d;
  logic signed [OW-1:0] da_d, db_d;
  logic                 ok0_d;
  logic signed [DW-1:0] dn;

  assign dn = $signed(dir_i[N]);

  always_comb begin
    if (HIGH) begin
      plane = NW'($signed(center_i[N])) + $signed({3'b000, half_i[N]});
    end else begin
      plane = NW'($signed(center_i[N])) - $signed({3'b000, half_i[N]});
    end
    num_d = plane - NW'($signed(org_i[N]));
    da_d  = OW'($signed(org_i[A])) - OW'($signed(center_i[A]));
    db_d  = OW'($signed(org_i[B])) - OW'($signed(center_i[B]));
    ok0_d = (dn != '0) && (num_d != '0) && (num_d[NW-1] == dn[DW-1]);
  end

  rbf_pkg::tag_t                 tag0_q, tag1_q, tag2_q;
  logic [2:0][COORD_WIDTH-1:0]   org0_q, org1_q, org2_q;
  logic [2:0][DW-1:0]            dir0_q, dir1_q, dir2_q;
  logic signed [NW-1:0]          num0_q;
  logic signed [OW-1:0]          da0_q, db0_q;
  logic                          ok0_q, ok1_q;

  // Stage 1: products of the scaled bound test.
  logic signed [DW-1:0]  dn0, dna0, dnb0;
  logic [DW-1:0]         adn0;
  logic signed [PW-1:0]  pa1_d, pb1_d, pc1_d, pd1_d;
  logic [PW-1:0]         ra1_d, rb1_d;
  logic signed [PW-1:0]  pa1_q, pb1_q, pc1_q, pd1_q;
  logic [PW-1:0]         ra1_q, rb1_q;

  always_comb begin
    dn0   = $signed(dir0_q[N]);
    dna0  = $signed(dir0_q[A]);
    dnb0  = $signed(dir0_q[B]);
    adn0  = dn0[DW-1] ? DW'(-dn0) : DW'(dn0);
    pa1_d = PW'(da0_q) * PW'(dn0);
    pb1_d = PW'(num0_q) * PW'(dna0);
    pc1_d = PW'(db0_q) * PW'(dn0);
    pd1_d = PW'(num0_q) * PW'(dnb0);
    ra1_d = PW'(half_i[A]) * PW'(adn0);
    rb1_d = PW'(half_i[B]) * PW'(adn0);
  end

  // Stage 2: sum, magnitude and compare, then merge with an earlier hit.
  logic signed [PW-1:0] sa, sb;
  logic [PW-1:0]        ma, mb;
  logic                 hit2;
  rbf_pkg::tag_t        tag2_d;

  always_comb begin
    sa   = pa1_q + pb1_q;
    sb   = pc1_q + pd1_q;
    ma   = sa[PW-1] ? PW'(-sa) : PW'(sa);
    mb   = sb[PW-1] ? PW'(-sb) : PW'(sb);
    hit2 = ok1_q && (ma <= ra1_q) && (mb <= rb1_q);
    tag2_d.valid = tag1_q.valid;
    if (tag1_q.face != rbf_pkg::FACE_NONE) begin
      tag2_d.face = tag1_q.face;
    end else if (hit2) begin
      tag2_d.face = FACE_ID;
    end else begin
      tag2_d.face = rbf_pkg::FACE_NONE;
    end
  end

  // Tags of the three stages: valid bit and face found so far.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
      tag1_q <= '0;
      tag2_q <= '0;
    end else if (en_i) begin
      tag0_q <= tag_i;
      tag1_q <= tag0_q;
      tag2_q <= tag2_d;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      org0_q      <= org_i;
      dir0_q      <= dir_i;
      num0_q      <= num_d;
      da0_q       <= da_d;
      db0_q       <= db_d;
      ok0_q       <= ok0_d;
      org1_q      <= org0_q;
      dir1_q      <= dir0_q;
      ok1_q       <= ok0_q;
      pa1_q       <= pa1_d;
      pb1_q       <= pb1_d;
      pc1_q       <= pc1_d;
      pd1_q       <= pd1_d;
      ra1_q       <= ra1_d;
      rb1_q       <= rb1_d;
      org2_q      <= org1_q;
      dir2_q      <= dir1_q;
    end
  end

  assign tag_o = tag2_q;
  assign org_o = org2_q;
  assign dir_o = dir2_q;
endmodule

// File: design/ray_box_face_hit_test_unit.sv
// Top level of the ray versus axis-aligned box first-face test.
// Depends on rbf_pkg, the channel interfaces in rbf_ifs and rbf_face_cell.
//
// Usage: ray_i carries one ray per beat (origin Q16.16, direction Q1.16).
// res_o returns one beat per ray, in order: hit and the first face hit,
// tried as z-low, z-high, y-low, y-high, x-low, x-high. cfg_i writes the
// box center and half sizes by register index; it is always ready, and an
// index beyond the half size of z is ignored. Writes belong between rays.
// The datapath is a chain of six face cells, one per face, each three
// register stages deep (offsets, products, bound compare). The result beat
// of an accepted ray is presented once it has passed every stage of all
// six cells; one ray is accepted per cycle while results are taken.
// Reset clears all valid bits and sets the box registers to zero. When
// the receiver stalls with a result waiting, the whole chain holds and
// ray_i.ready drops in the same cycle.
module ray_box_face_hit_test_unit #(
  parameter int COORD_WIDTH   = rbf_pkg::COORD_WIDTH_DEF,
  parameter int DIR_FRAC_BITS = rbf_pkg::DIR_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbf_ray_if.sink   ray_i,
  rbf_hit_if.source res_o,
  rbf_cfg_if.sink   cfg_i
);
  localparam int DW = DIR_FRAC_BITS + 2;

  logic [2:0][COORD_WIDTH-1:0] center_q;
  logic [2:0][COORD_WIDTH-2:0] half_q;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      half_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rbf_pkg::REG_CENTER_X: center_q[0] <= cfg_i.data;
        rbf_pkg::REG_CENTER_Y: center_q[1] <= cfg_i.data;
        rbf_pkg::REG_CENTER_Z: center_q[2] <= cfg_i.data;
        rbf_pkg::REG_HALF_X:   half_q[0]   <= cfg_i.data[COORD_WIDTH-2:0];
        rbf_pkg::REG_HALF_Y:   half_q[1]   <= cfg_i.data[COORD_WIDTH-2:0];
        rbf_pkg::REG_HALF_Z:   half_q[2]   <= cfg_i.data[COORD_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  // Chain links; link 0 is the input beat, link 6 the output register.
  rbf_pkg::tag_t               tag   [7];
  logic [2:0][COORD_WIDTH-1:0] org   [7];
  logic [2:0][DW-1:0]          dir   [7];
  logic                        adv;

  assign adv         = !tag[6].valid || res_o.ready;
  assign ray_i.ready = adv;

  assign tag[0].valid = ray_i.valid;
  assign tag[0].face  = rbf_pkg::FACE_NONE;
  assign org[0]       = {ray_i.origin_z, ray_i.origin_y, ray_i.origin_x};
  assign dir[0]       = {ray_i.dir_z, ray_i.dir_y, ray_i.dir_x};

  // Six face cells in priority order.
  for (genvar g = 0; g < 6; g++) begin : g_cell
    rbf_face_cell #(
      .COORD_WIDTH  (COORD_WIDTH),
      .DIR_FRAC_BITS(DIR_FRAC_BITS),
      .FACE_ID      (rbf_pkg::face_e'(g + 1))
    ) u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (adv),
      .tag_i   (tag[g]),
      .org_i   (org[g]),
      .dir_i   (dir[g]),
      .center_i(center_q),
      .half_i  (half_q),
      .tag_o   (tag[g+1]),
      .org_o   (org[g+1]),
      .dir_o   (dir[g+1])
    );
  end

  assign res_o.valid = tag[6].valid;
  assign res_o.face  = tag[6].face;
  assign res_o.hit   = tag[6].face != rbf_pkg::FACE_NONE;
endmodule

// File: design/rbf_checker.sv
// Port-level checks on the ray box face hit test unit, bound to the top.
// Depends on rbf_pkg for face codes.
module rbf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           out_hit_i,
  input logic [rbf_pkg::FACE_WIDTH-1:0] out_face_i
);
  // Hit flag agrees with the face code.
  a_hit_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_hit_i == (out_face_i != rbf_pkg::FACE_NONE)))
    else $error("hit flag disagrees with face");

  // Face code stays in range.
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_face_i <= rbf_pkg::FACE_X_HIGH))
    else $error("face code out of range");

  // Input stalls only behind a waiting result beat.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without output backpressure");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_face_i)))
    else $error("stalled result changed");
endmodule

bind ray_box_face_hit_test_unit rbf_checker u_rbf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (ray_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .out_hit_i  (res_o.hit),
  .out_face_i (res_o.face)
);
